// ----- sv/frame_ordered_event_queue_assert.svh -----
// Assertion macros used by the event queue top level.
`ifndef FRAME_ORDERED_EVENT_QUEUE_ASSERT_SVH
`define FRAME_ORDERED_EVENT_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FOEQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("event queue check failed");

// Next-cycle implication, checked outside reset.
`define FOEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("event queue check failed");

`endif

// ----- sv/foeq_pkg.sv -----
// Shared types, codes and defaults for the frame-ordered event queue.
package foeq_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int TAG_BITS_DEF    = 16;
   localparam int FRAME_BITS      = 32;
   localparam int TAG_FIELD_BITS  = 16;

   localparam logic CMD_SCHEDULE = 1'b0;
   localparam logic CMD_EXECUTE  = 1'b1;

   localparam logic [1:0] KIND_INSERTED = 2'd0;
   localparam logic [1:0] KIND_REFUSED  = 2'd1;
   localparam logic [1:0] KIND_DUE      = 2'd2;
   localparam logic [1:0] KIND_NONE     = 2'd3;

   typedef struct packed {
      logic                                command;
      logic signed [FRAME_BITS-1:0]        frame;
      logic        [TAG_FIELD_BITS-1:0]    tag;
   } req_type;

   typedef struct packed {
      logic [1:0]                          kind;
      logic        [TAG_FIELD_BITS-1:0]    due_tag;
      logic signed [FRAME_BITS-1:0]        due_frame;
      logic [4:0]                          entry_count;
      logic                                last;
   } rsp_type;

   typedef struct packed {
      logic insert;
      logic pop;
   } cell_ctl_type;

   typedef enum logic {
      ST_IDLE,
      ST_DRAIN
   } state_type;

endpackage

// ----- sv/foeq_cell.sv -----
// One slot of the sorted entry chain; shifts toward the tail on insert, toward the head on pop.
module foeq_cell
   import foeq_pkg::*;
#(
   parameter int TAG_BITS = TAG_BITS_DEF
) (
   input  logic                         clock,
   input  cell_ctl_type                 ctl,
   input  logic                         occupied,
   input  logic signed [FRAME_BITS-1:0] key_frame,
   input  logic signed [FRAME_BITS-1:0] new_frame,
   input  logic        [TAG_BITS-1:0]   new_tag,
   input  logic                         prev_ge,
   input  logic signed [FRAME_BITS-1:0] prev_frame,
   input  logic        [TAG_BITS-1:0]   prev_tag,
   input  logic signed [FRAME_BITS-1:0] next_frame,
   input  logic        [TAG_BITS-1:0]   next_tag,
   output logic                         key_ge,
   output logic signed [FRAME_BITS-1:0] frame_out,
   output logic        [TAG_BITS-1:0]   tag_out
);

   logic signed [FRAME_BITS-1:0] frame_ff, frame_in;
   logic        [TAG_BITS-1:0]   tag_ff, tag_in;

   // An occupied slot at or before the key stays ahead of a new entry.
   assign key_ge    = occupied && (frame_ff <= key_frame);
   assign frame_out = frame_ff;
   assign tag_out   = tag_ff;

   always_comb begin
      frame_in = frame_ff;
      tag_in   = tag_ff;
      if (ctl.pop) begin
         frame_in = next_frame;
         tag_in   = next_tag;
      end else if (ctl.insert && !key_ge) begin
         if (prev_ge) begin
            frame_in = new_frame;
            tag_in   = new_tag;
         end else begin
            frame_in = prev_frame;
            tag_in   = prev_tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      tag_ff   <= tag_in;
   end

endmodule

// ----- sv/frame_ordered_event_queue.sv -----
// Top level of the frame-ordered event queue: cell chain, sequencer and response register.
//
// A schedule request drops the new entry into its sorted place in the cell chain, and one
// response with the new count follows. An execute request gives one response per due entry
// it removes (one response when nothing is due), since the chain moves one entry off its head
// per cycle while the response slot is free; no new request is taken until the last response
// of an execute has been loaded. A new request is taken in the same cycle that the waiting
// response is taken, so requests can follow back to back while the receiver keeps ready high.
// Among entries with equal frames the older one leaves first. A full queue refuses a schedule.
module frame_ordered_event_queue
   import foeq_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   parameter int TAG_BITS    = TAG_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   `include "frame_ordered_event_queue_assert.svh"

   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int KEEP_W  = (TAG_BITS < TAG_FIELD_BITS) ? TAG_BITS : TAG_FIELD_BITS;

   state_type                    state_ff, state_in;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic signed [FRAME_BITS-1:0] exec_frame_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   rsp_type                      rsp_ff, rsp_in;
   logic                         load_rsp;
   cell_ctl_type                 ctl;

   logic signed [FRAME_BITS-1:0] key_frame;
   logic        [TAG_BITS-1:0]   new_tag;
   logic                         slot_free, req_fire, is_exec, full, head_due, next_due;

   logic                         ge_q    [QUEUE_DEPTH];
   logic signed [FRAME_BITS-1:0] frame_q [QUEUE_DEPTH];
   logic        [TAG_BITS-1:0]   tag_q   [QUEUE_DEPTH];

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire  = req_valid && req_ready;
   assign is_exec   = req_payload.command == CMD_EXECUTE;
   assign full      = count_ff == COUNT_W'(QUEUE_DEPTH);
   assign key_frame = (state_ff == ST_DRAIN) ? exec_frame_ff : req_payload.frame;
   assign new_tag   = TAG_BITS'(req_payload.tag[KEEP_W-1:0]);
   assign head_due  = ge_q[0];
   assign next_due  = ge_q[1];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                         prev_ge;
      logic signed [FRAME_BITS-1:0] prev_frame, next_frame;
      logic        [TAG_BITS-1:0]   prev_tag, next_tag;

      if (i == 0) begin : g_head
         assign prev_ge    = 1'b1;
         assign prev_frame = req_payload.frame;
         assign prev_tag   = new_tag;
      end else begin : g_body
         assign prev_ge    = ge_q[i-1];
         assign prev_frame = frame_q[i-1];
         assign prev_tag   = tag_q[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_frame = frame_q[i];
         assign next_tag   = tag_q[i];
      end else begin : g_inner
         assign next_frame = frame_q[i+1];
         assign next_tag   = tag_q[i+1];
      end

      foeq_cell #(
         .TAG_BITS (TAG_BITS)
      ) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .occupied   (COUNT_W'(i) < count_ff),
         .key_frame  (key_frame),
         .new_frame  (req_payload.frame),
         .new_tag    (new_tag),
         .prev_ge    (prev_ge),
         .prev_frame (prev_frame),
         .prev_tag   (prev_tag),
         .next_frame (next_frame),
         .next_tag   (next_tag),
         .key_ge     (ge_q[i]),
         .frame_out  (frame_q[i]),
         .tag_out    (tag_q[i])
      );
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && is_exec && head_due && next_due) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (slot_free && !next_due) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: chain control, count update and the response to load.
   always_comb begin
      ctl                = '0;
      load_rsp           = 1'b0;
      count_in           = count_ff;
      rsp_in             = '0;
      rsp_in.entry_count = 5'(count_ff);
      rsp_in.last        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               load_rsp = 1'b1;
               if (!is_exec) begin
                  if (full) begin
                     rsp_in.kind = KIND_REFUSED;
                  end else begin
                     ctl.insert         = 1'b1;
                     count_in           = count_ff + 1'b1;
                     rsp_in.kind        = KIND_INSERTED;
                     rsp_in.entry_count = 5'(count_in);
                  end
               end else if (head_due) begin
                  ctl.pop            = 1'b1;
                  count_in           = count_ff - 1'b1;
                  rsp_in.kind        = KIND_DUE;
                  rsp_in.due_tag     = TAG_FIELD_BITS'(tag_q[0][KEEP_W-1:0]);
                  rsp_in.due_frame   = frame_q[0];
                  rsp_in.entry_count = 5'(count_in);
                  rsp_in.last        = !next_due;
               end else begin
                  rsp_in.kind = KIND_NONE;
               end
            end
         end
         ST_DRAIN: begin
            if (slot_free) begin
               load_rsp           = 1'b1;
               ctl.pop            = 1'b1;
               count_in           = count_ff - 1'b1;
               rsp_in.kind        = KIND_DUE;
               rsp_in.due_tag     = TAG_FIELD_BITS'(tag_q[0][KEEP_W-1:0]);
               rsp_in.due_frame   = frame_q[0];
               rsp_in.entry_count = 5'(count_in);
               rsp_in.last        = !next_due;
            end
         end
         default: begin
            load_rsp = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         exec_frame_ff <= req_payload.frame;
      end
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `FOEQ_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= COUNT_W'(QUEUE_DEPTH))
   `FOEQ_ASSERT_NOW(a_drain_has_entry, state_ff == ST_DRAIN, count_ff != '0)
   `FOEQ_ASSERT_NOW(a_partial_means_drain, rsp_valid_ff && !rsp_ff.last, state_ff == ST_DRAIN)
   `FOEQ_ASSERT_NEXT(a_insert_counts,
      req_fire && !is_exec && !full, count_ff == $past(count_ff) + 1'b1)

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the frame-ordered event queue.
`timescale 1ns / 1ps

module tb;
   import foeq_pkg::*;

   localparam int DEPTH       = QUEUE_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_WAIT  = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   // Shadow copy of the sorted store: latest frame at index 0, earliest at the top.
   logic signed [FRAME_BITS-1:0]     shadow_frames[DEPTH];
   logic        [TAG_FIELD_BITS-1:0] shadow_tags[DEPTH];
   int shadow_count = 0;

   int accepted_reqs = 0;
   int total_reqs = 0;
   int failures = 0;
   int cycle_count = 0;

   frame_ordered_event_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH_DEF),
      .TAG_BITS(TAG_BITS_DEF)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Idle percentage for each side; the two sides swap rates after a third of the requests,
   // and neither idles in the last third.
   function automatic int gap_percent(input bit for_sender);
      if (accepted_reqs < total_reqs / 3)
         return for_sender ? 8 : 47;
      else if (accepted_reqs < (2 * total_reqs) / 3)
         return for_sender ? 47 : 8;
      return 0;
   endfunction

   task automatic predict_responses(input req_type r);
      logic signed [FRAME_BITS-1:0] f;
      rsp_type resp;
      int pos;
      int i;
      bit popped;
      begin
         f = r.frame;
         resp = '0;
         resp.last = 1'b1;
         popped = 1'b0;
         if (r.command == CMD_SCHEDULE) begin
            if (shadow_count >= DEPTH) begin
               resp.kind = KIND_REFUSED;
            end else begin
               // The new entry goes below older entries with an equal frame.
               pos = 0;
               while (pos < shadow_count && f < shadow_frames[pos])
                  pos++;
               for (i = shadow_count; i > pos; i--) begin
                  shadow_frames[i] = shadow_frames[i-1];
                  shadow_tags[i] = shadow_tags[i-1];
               end
               shadow_frames[pos] = f;
               shadow_tags[pos] = r.tag;
               shadow_count++;
               resp.kind = KIND_INSERTED;
            end
            resp.entry_count = 5'(shadow_count);
            expected_rsps.push_back(resp);
         end else begin
            while (shadow_count > 0 && shadow_frames[shadow_count-1] <= f) begin
               shadow_count--;
               resp.kind = KIND_DUE;
               resp.due_tag = shadow_tags[shadow_count];
               resp.due_frame = shadow_frames[shadow_count];
               resp.entry_count = 5'(shadow_count);
               resp.last = (shadow_count == 0) || (shadow_frames[shadow_count-1] > f);
               expected_rsps.push_back(resp);
               popped = 1'b1;
            end
            if (!popped) begin
               resp.kind = KIND_NONE;
               resp.entry_count = 5'(shadow_count);
               expected_rsps.push_back(resp);
            end
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
         failures++;
      end
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_responses(req_payload);
            accepted_reqs++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= gap_percent(1'b1)) begin
               req_payload <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response, expected none, got %p", $time, rsp_payload);
               failures++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("kind", 32'(want.kind), 32'(rsp_payload.kind));
               check_field("due_tag", 32'(want.due_tag), 32'(rsp_payload.due_tag));
               check_field("due_frame", want.due_frame, rsp_payload.due_frame);
               check_field("entry_count", 32'(want.entry_count),
                           32'(rsp_payload.entry_count));
               check_field("last", 32'(want.last), 32'(rsp_payload.last));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= gap_percent(1'b0));
      end
   end

   task automatic add_req(input logic cmd, input logic signed [FRAME_BITS-1:0] f,
                          input logic [TAG_FIELD_BITS-1:0] t);
      req_type r;
      begin
         r.command = cmd;
         r.frame = f;
         r.tag = t;
         pending_reqs.push_back(r);
      end
   endtask

   initial begin
      logic signed [FRAME_BITS-1:0] now_frame;
      logic signed [FRAME_BITS-1:0] f;
      int made;
      int k;
      int j;

      // Directed part: empty execute, extreme frames, equal frames, full queue, full drain.
      add_req(CMD_EXECUTE, 32'sd0, 16'h0000);
      add_req(CMD_SCHEDULE, 32'sh7FFFFFFF, 16'hFFFF);
      add_req(CMD_SCHEDULE, 32'sh80000000, 16'h0000);
      add_req(CMD_SCHEDULE, 32'sd0, 16'h1234);
      add_req(CMD_SCHEDULE, -32'sd1, 16'h5555);
      add_req(CMD_SCHEDULE, 32'sd0, 16'hAAAA);
      add_req(CMD_EXECUTE, -32'sd2, 16'hFFFF);
      add_req(CMD_EXECUTE, 32'sd0, 16'h0000);
      add_req(CMD_EXECUTE, 32'sh7FFFFFFF, 16'h0000);
      for (j = 0; j < DEPTH; j++)
         add_req(CMD_SCHEDULE, ((j * 7) % 5) - 2, j[15:0]);
      add_req(CMD_SCHEDULE, 32'sd0, 16'hBEEF);
      add_req(CMD_EXECUTE, 32'sh7FFFFFFF, 16'h0000);

      // Random part: bursts of schedules near a moving frame, then executes that catch up.
      now_frame = $urandom;
      made = pending_reqs.size();
      while (made < 250) begin
         if ($urandom_range(0, 99) < 10) begin
            add_req(1'($urandom_range(0, 1)), $urandom, 16'($urandom_range(0, 65535)));
            made++;
         end else begin
            k = $urandom_range(1, 18);
            for (j = 0; j < k; j++) begin
               if ($urandom_range(0, 99) < 5)
                  f = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
               else
                  f = now_frame + $urandom_range(0, 24);
               add_req(CMD_SCHEDULE, f, 16'($urandom_range(0, 65535)));
            end
            k = $urandom_range(1, 3);
            for (j = 0; j < k; j++)
               add_req(CMD_EXECUTE, now_frame + $urandom_range(0, 30),
                       16'($urandom_range(0, 65535)));
            made = pending_reqs.size();
            now_frame = now_frame + $urandom_range(5, 30);
         end
      end
      total_reqs = pending_reqs.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (accepted_reqs < total_reqs)
         @(posedge clock);
      while (expected_rsps.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
